/* rtl/ufm_pkg.sv */
// ----------------------------------------------------------------------------
// ufm_pkg
// Shared types and constants for the ultrasonic frame trimmed-mean block.
// ----------------------------------------------------------------------------
package ufm_pkg;

    localparam int DIST_W         = 16;
    localparam int TICK_W         = 32;
    localparam int BYTE_W         = 8;
    localparam int EVENT_W        = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int RING_DEPTH_DEF = 5;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd2;

    localparam logic [DIST_W-1:0] MIN_DIST_RST = 16'd280;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 16'd2500;
    localparam logic [TICK_W-1:0] TIMEOUT_RST  = 32'd10000;

    // Frame event codes.
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_VALID  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_BADSUM = 2'd2;
    localparam logic [EVENT_W-1:0] EV_RANGE  = 2'd3;

    // Input item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Controls from the sequencer to the mean unit.
    typedef struct packed {
        logic first;
        logic acc;
        logic trim;
        logic mult;
    } mean_ctrl_t;

endpackage

/* rtl/ufm_if.sv */
// ----------------------------------------------------------------------------
// ufm_if
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface ufm_item_if import ufm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, kind, rx_byte, input ready);
    modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface ufm_result_if import ufm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DIST_W-1:0]  filtered_mm;
    logic               status_ok;
    logic [EVENT_W-1:0] frame_event;
    logic [DIST_W-1:0]  frame_mm;

    modport source (output valid, filtered_mm, status_ok, frame_event, frame_mm, input ready);
    modport sink   (input valid, filtered_mm, status_ok, frame_event, frame_mm, output ready);
endinterface

/* rtl/ufm_cell.sv */
// ----------------------------------------------------------------------------
// ufm_cell
// One sample cell of the ring; loads its neighbor's value when enabled.
// ----------------------------------------------------------------------------
module ufm_cell import ufm_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DIST_W-1:0] d,
    output logic [DIST_W-1:0] q
);

    logic [DIST_W-1:0] sample_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample_reg <= d;
        end
    end

    assign q = sample_reg;

endmodule

/* rtl/ufm_mean.sv */
// ----------------------------------------------------------------------------
// ufm_mean
// Accumulates sum, minimum and maximum of the samples streamed out of the
// ring, then divides the trimmed sum by a reciprocal multiplication.
// ----------------------------------------------------------------------------
module ufm_mean import ufm_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic              clk,
    input  mean_ctrl_t        ctrl,
    input  logic [DIST_W-1:0] sample,
    output logic [DIST_W-1:0] quotient
);

    localparam int SUM_W   = DIST_W + $clog2(RING_DEPTH + 1);
    localparam int DIVISOR = RING_DEPTH - 2;
    localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // ceil(2^SHIFT / DIVISOR) gives an exact quotient for every sum below 2^SUM_W.
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [SUM_W-1:0]  sum_reg;
    logic [DIST_W-1:0] lo_reg;
    logic [DIST_W-1:0] hi_reg;
    logic [SUM_W-1:0]  trim_reg;
    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.acc)
        begin
            if (ctrl.first)
            begin
                sum_reg <= SUM_W'(sample);
                lo_reg  <= sample;
                hi_reg  <= sample;
            end
            else
            begin
                sum_reg <= sum_reg + SUM_W'(sample);
                if (sample < lo_reg)
                begin
                    lo_reg <= sample;
                end
                if (sample > hi_reg)
                begin
                    hi_reg <= sample;
                end
            end
        end
        if (ctrl.trim)
        begin
            trim_reg <= sum_reg - SUM_W'(lo_reg) - SUM_W'(hi_reg);
        end
        if (ctrl.mult)
        begin
            prod_reg <= PROD_W'(trim_reg) * PROD_W'(RECIP);
        end
    end

    assign quotient = prod_reg[SHIFT +: DIST_W];

endmodule

/* rtl/ultrasonic_frame_trimmed_mean_top.sv */
// ----------------------------------------------------------------------------
// ultrasonic_frame_trimmed_mean_top
// Frame parser, tick counter and trimmed-mean filter over a ring of cells.
// ----------------------------------------------------------------------------
//  channel   role    handshake     payload
//  item      sink    valid/ready   kind, rx_byte
//  result    source  valid/ready   filtered_mm, status_ok, frame_event, frame_mm
//  cfg       write   cfg_we        cfg_index, cfg_data
//
//  An item passes the idle, evaluate and done states; once the ring is full and
//  no timeout is pending, the walk of the sample ring through the mean unit
//  (one cell per cycle) plus trim, multiply and latch lies between evaluate and done.
//  Reset is asynchronous and active low; no clearing pass is needed.
//  A new item is taken while the previous result still waits in the output
//  register; the finished result holds until the output register is free.
// ----------------------------------------------------------------------------
module ultrasonic_frame_trimmed_mean_top import ufm_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ufm_item_if.sink              item,
    ufm_result_if.source          result
);

    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int ROT_W  = $clog2(RING_DEPTH);

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_SUM  = 2'd3;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_ROTATE = 3'd2;
    localparam logic [2:0] S_TRIM   = 3'd3;
    localparam logic [2:0] S_MULT   = 3'd4;
    localparam logic [2:0] S_LATCH  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [DIST_W-1:0]  min_reg;
    logic [DIST_W-1:0]  max_reg;
    logic [TICK_W-1:0]  timeout_reg;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [1:0]         phase_reg;
    logic [BYTE_W-1:0]  high_reg;
    logic [BYTE_W-1:0]  low_reg;
    logic [TICK_W-1:0]  ticks_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [ROT_W-1:0]   rot_reg;
    logic [DIST_W-1:0]  held_dist_reg;
    logic               held_ok_reg;
    logic [EVENT_W-1:0] event_reg;
    logic [DIST_W-1:0]  fmm_reg;

    logic               out_valid_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic               out_ok_reg;
    logic [EVENT_W-1:0] out_event_reg;
    logic [DIST_W-1:0]  out_fmm_reg;

    logic               accept;
    logic               is_byte;
    logic [BYTE_W-1:0]  csum;
    logic [DIST_W-1:0]  frame_dist;
    logic               frame_end;
    logic               sum_good;
    logic               in_range;
    logic               push;
    logic               rotating;
    logic               out_free;
    mean_ctrl_t         mctrl;
    logic [DIST_W-1:0]  quotient;
    logic [DIST_W-1:0]  cell_q [RING_DEPTH];

    assign accept     = item.valid && item.ready;
    assign is_byte    = (item.kind == KIND_BYTE);
    assign csum       = HEADER_BYTE + high_reg + low_reg;
    assign frame_dist = {high_reg, low_reg};
    assign frame_end  = accept && is_byte && (phase_reg == PH_SUM);
    assign sum_good   = (csum == item.rx_byte);
    assign in_range   = !(frame_dist < min_reg) && !(frame_dist > max_reg);
    assign push       = frame_end && sum_good && in_range;
    assign rotating   = (state_reg == S_ROTATE);
    assign out_free   = !out_valid_reg || result.ready;

    assign item.ready = (state_reg == S_IDLE);

    // Sample ring: a push shifts a new sample in at the front and drops the
    // oldest; a walk rotates the ring once around past the mean unit.
    for (genvar i = 0; i < RING_DEPTH; i++)
    begin : g_ring
        logic [DIST_W-1:0] d;
        if (i == 0)
        begin : g_head
            assign d = push ? frame_dist : cell_q[RING_DEPTH-1];
        end
        else
        begin : g_body
            assign d = cell_q[i-1];
        end
        ufm_cell u_cell
        (
            .clk (clk),
            .en  (push || rotating),
            .d   (d),
            .q   (cell_q[i])
        );
    end

    assign mctrl.first = (rot_reg == '0);
    assign mctrl.acc   = rotating;
    assign mctrl.trim  = (state_reg == S_TRIM);
    assign mctrl.mult  = (state_reg == S_MULT);

    ufm_mean #(.RING_DEPTH(RING_DEPTH)) u_mean
    (
        .clk      (clk),
        .ctrl     (mctrl),
        .sample   (cell_q[RING_DEPTH-1]),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (ticks_reg > timeout_reg)
                begin
                    state_next = S_DONE;
                end
                else if (fill_reg == FILL_W'(RING_DEPTH))
                begin
                    state_next = S_ROTATE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ROTATE:
            begin
                if (rot_reg == ROT_W'(RING_DEPTH - 1))
                begin
                    state_next = S_TRIM;
                end
            end
            S_TRIM:  state_next = S_MULT;
            S_MULT:  state_next = S_LATCH;
            S_LATCH: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= MIN_DIST_RST;
            max_reg       <= MAX_DIST_RST;
            timeout_reg   <= TIMEOUT_RST;
            state_reg     <= S_IDLE;
            phase_reg     <= PH_WAIT;
            high_reg      <= '0;
            low_reg       <= '0;
            ticks_reg     <= '0;
            fill_reg      <= '0;
            rot_reg       <= '0;
            held_dist_reg <= '0;
            held_ok_reg   <= 1'b0;
            event_reg     <= EV_NONE;
            fmm_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_dist_reg  <= '0;
            out_ok_reg    <= 1'b0;
            out_event_reg <= EV_NONE;
            out_fmm_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MIN_DIST: min_reg     <= cfg_data[DIST_W-1:0];
                    REG_MAX_DIST: max_reg     <= cfg_data[DIST_W-1:0];
                    REG_TIMEOUT:  timeout_reg <= cfg_data[TICK_W-1:0];
                    default:      ;
                endcase
            end

            if (accept)
            begin
                fmm_reg <= frame_end ? frame_dist : '0;
                if (!frame_end)
                begin
                    event_reg <= EV_NONE;
                end
                else if (!sum_good)
                begin
                    event_reg <= EV_BADSUM;
                end
                else if (!in_range)
                begin
                    event_reg <= EV_RANGE;
                end
                else
                begin
                    event_reg <= EV_VALID;
                end

                if (!is_byte)
                begin
                    if (ticks_reg != '1)
                    begin
                        ticks_reg <= ticks_reg + TICK_W'(1);
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_WAIT:
                        begin
                            if (item.rx_byte == HEADER_BYTE)
                            begin
                                phase_reg <= PH_HIGH;
                            end
                        end
                        PH_HIGH:
                        begin
                            high_reg  <= item.rx_byte;
                            phase_reg <= PH_LOW;
                        end
                        PH_LOW:
                        begin
                            low_reg   <= item.rx_byte;
                            phase_reg <= PH_SUM;
                        end
                        default:
                        begin
                            phase_reg <= PH_WAIT;
                            if (push)
                            begin
                                ticks_reg <= '0;
                                if (fill_reg != FILL_W'(RING_DEPTH))
                                begin
                                    fill_reg <= fill_reg + FILL_W'(1);
                                end
                            end
                        end
                    endcase
                end
            end

            if ((state_reg == S_EVAL) && (ticks_reg > timeout_reg))
            begin
                held_ok_reg   <= 1'b0;
                held_dist_reg <= '0;
            end

            if (rotating)
            begin
                rot_reg <= (rot_reg == ROT_W'(RING_DEPTH - 1)) ? '0 : rot_reg + ROT_W'(1);
            end

            if (state_reg == S_LATCH)
            begin
                held_ok_reg   <= 1'b1;
                held_dist_reg <= quotient;
            end

            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_dist_reg  <= held_dist_reg;
                out_ok_reg    <= held_ok_reg;
                out_event_reg <= event_reg;
                out_fmm_reg   <= fmm_reg;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.filtered_mm = out_dist_reg;
    assign result.status_ok   = out_ok_reg;
    assign result.frame_event = out_event_reg;
    assign result.frame_mm    = out_fmm_reg;

    // A fault result always carries a zero distance.
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.status_ok) |-> (result.filtered_mm == '0))
        else $error("fault result with nonzero distance");

    // Only a completed frame reports a distance.
    a_event_mm: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.frame_event == EV_NONE)) |-> (result.frame_mm == '0))
        else $error("frame distance without a frame event");

    // The fill count never passes the ring depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(RING_DEPTH))
        else $error("fill count beyond ring depth");

    // A walk of the ring starts only with a full ring.
    a_walk_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rotating) |-> (fill_reg == FILL_W'(RING_DEPTH)))
        else $error("ring walk started before the ring was full");

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the ultrasonic frame trimmed-mean block. A short table of
// directed items covers header hunting, checksum and range rejection and the
// field extremes; random traffic of mostly well-formed frames and tick bursts
// then runs under several limit and timeout settings. Every result is checked
// field by field against an in-order queue of table or predicted readings.
// ----------------------------------------------------------------------------
module tb_top import ufm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_N      = RING_DEPTH_DEF;
    localparam int SETTLE      = 24;
    localparam int HOLD_LONG   = 300;
    localparam int PHASE_ITEMS = 218;
    localparam int LIMIT       = 600000;

    // Index past the end of the register list; the block must ignore it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {SEEK_HDR, TAKE_HIGH, TAKE_LOW, TAKE_SUM} parse_st_t;

    typedef struct packed {
        logic [DIST_W-1:0]  filtered_mm;
        logic               status_ok;
        logic [EVENT_W-1:0] frame_event;
        logic [DIST_W-1:0]  frame_mm;
    } reading_t;

    typedef struct packed {
        logic              typed;
        logic              kind;
        logic [BYTE_W-1:0] data;
        reading_t          want;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIR_TBL [0:DIR_ROWS-1] = '{
        '{1'b1, KIND_TICK, 8'h00, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'h00, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'h55, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        // Bad checksum.
        '{1'b1, KIND_BYTE, 8'hFF, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'h01, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'h02, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'h00, '{16'd0, 1'b0, EV_BADSUM, 16'h0102}},
        // Good checksum, distance below the lower limit.
        '{1'b1, KIND_BYTE, 8'hFF, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'h00, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'h01, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'h00, '{16'd0, 1'b0, EV_RANGE, 16'h0001}},
        // A header value in the high byte position is plain data.
        '{1'b1, KIND_BYTE, 8'hFF, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'hFF, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'h00, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'hFE, '{16'd0, 1'b0, EV_RANGE, 16'hFF00}},
        // Largest distance.
        '{1'b1, KIND_BYTE, 8'hFF, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'hFF, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'hFF, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'hFD, '{16'd0, 1'b0, EV_RANGE, 16'hFFFF}},
        // Valid frame of 1000 mm; the ring is not full so the outputs hold.
        '{1'b1, KIND_BYTE, 8'hFF, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'h03, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'hE8, '{16'd0, 1'b0, EV_NONE, 16'h0000}},
        '{1'b1, KIND_BYTE, 8'hEA, '{16'd0, 1'b0, EV_VALID, 16'd1000}},
        '{1'b0, KIND_TICK, 8'hFF, '{16'd0, 1'b0, EV_NONE, 16'h0000}}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ufm_item_if   item_ch ();
    ufm_result_if res_ch ();

    ultrasonic_frame_trimmed_mean_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (res_ch)
    );

    // Predictor state.
    logic [DIST_W-1:0] ring [RING_N];
    int                slot;
    int                fill;
    logic [TICK_W-1:0] ticks_idle;
    parse_st_t         parse_st;
    logic [BYTE_W-1:0] hi_b;
    logic [BYTE_W-1:0] lo_b;
    logic [DIST_W-1:0] held_mm;
    logic              held_ok;
    logic [DIST_W-1:0] lim_min;
    logic [DIST_W-1:0] lim_max;
    logic [TICK_W-1:0] lim_timeout;

    reading_t pending_readings [$];
    int       fail_count;
    int       items_sent;
    int       cycles;
    int       hold_cycles;
    bit       tx_idle;
    bit       rx_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [DIST_W-1:0] trimmed_mean();
        logic [19:0]       total;
        logic [DIST_W-1:0] lo;
        logic [DIST_W-1:0] hi;
        total = '0;
        lo    = ring[0];
        hi    = ring[0];
        for (int i = 0; i < RING_N; i++)
        begin
            total = total + ring[i];
            if (ring[i] < lo) lo = ring[i];
            if (ring[i] > hi) hi = ring[i];
        end
        total = 20'((total - lo - hi) / (RING_N - 2));
        return total[DIST_W-1:0];
    endfunction

    function automatic reading_t predict_reading(input logic k, input logic [BYTE_W-1:0] d);
        reading_t          r;
        logic [BYTE_W-1:0] sum;
        logic [DIST_W-1:0] dist_mm;
        r.frame_event = EV_NONE;
        r.frame_mm    = '0;
        if (k == KIND_TICK)
        begin
            if (ticks_idle != '1) ticks_idle = ticks_idle + 1'b1;
        end
        else
        begin
            case (parse_st)
                SEEK_HDR:
                begin
                    if (d == HEADER_BYTE) parse_st = TAKE_HIGH;
                end
                TAKE_HIGH:
                begin
                    hi_b     = d;
                    parse_st = TAKE_LOW;
                end
                TAKE_LOW:
                begin
                    lo_b     = d;
                    parse_st = TAKE_SUM;
                end
                default:
                begin
                    sum        = HEADER_BYTE + hi_b + lo_b;
                    dist_mm    = {hi_b, lo_b};
                    r.frame_mm = dist_mm;
                    if (sum != d)
                        r.frame_event = EV_BADSUM;
                    else if (dist_mm < lim_min || dist_mm > lim_max)
                        r.frame_event = EV_RANGE;
                    else
                    begin
                        r.frame_event = EV_VALID;
                        ring[slot]    = dist_mm;
                        slot          = (slot == RING_N - 1) ? 0 : slot + 1;
                        if (fill < RING_N) fill++;
                        ticks_idle    = '0;
                    end
                    parse_st = SEEK_HDR;
                end
            endcase
        end
        if (ticks_idle > lim_timeout)
        begin
            held_ok = 1'b0;
            held_mm = '0;
        end
        else if (fill == RING_N)
        begin
            held_ok = 1'b1;
            held_mm = trimmed_mean();
        end
        r.filtered_mm = held_mm;
        r.status_ok   = held_ok;
        return r;
    endfunction

    task automatic send_item(input logic k, input logic [BYTE_W-1:0] d,
                             input logic use_typed, input reading_t typed);
        int       gap;
        reading_t p;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.kind    <= k;
        item_ch.rx_byte <= d;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        p = predict_reading(k, d);
        pending_readings.push_back(use_typed ? typed : p);
        items_sent++;
    endtask

    // Stops offering items and waits until every reading has come back.
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_MIN_DIST: lim_min     = val[DIST_W-1:0];
            REG_MAX_DIST: lim_max     = val[DIST_W-1:0];
            REG_TIMEOUT:  lim_timeout = val[TICK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [DIST_W-1:0] mn, input logic [DIST_W-1:0] mx,
                              input logic [TICK_W-1:0] tmo);
        write_reg(REG_MIN_DIST, {{(CFG_DATA_W-DIST_W){1'b0}}, mn});
        write_reg(REG_MAX_DIST, {{(CFG_DATA_W-DIST_W){1'b0}}, mx});
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_UNUSED, $urandom());
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Distances cluster on the limits and just outside them.
    function automatic logic [DIST_W-1:0] pick_distance();
        logic [DIST_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = lim_min;
            1: v = lim_max;
            2: v = lim_min - 1'b1;
            3: v = lim_max + 1'b1;
            4:
            begin
                if (lim_min <= lim_max)
                    v = lim_min + 16'($urandom_range(0, lim_max - lim_min));
                else
                    v = 16'($urandom_range(0, 65535));
            end
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    task automatic send_frame(input logic [DIST_W-1:0] dist_mm, input bit corrupt);
        logic [BYTE_W-1:0] sum;
        sum = HEADER_BYTE + dist_mm[15:8] + dist_mm[7:0];
        if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
        send_item(KIND_BYTE, HEADER_BYTE, 1'b0, '0);
        send_item(KIND_BYTE, dist_mm[15:8], 1'b0, '0);
        send_item(KIND_BYTE, dist_mm[7:0], 1'b0, '0);
        send_item(KIND_BYTE, sum, 1'b0, '0);
    endtask

    task automatic run_traffic(input int count, input int hold_at, input int pause_at);
        int start;
        int len;
        int span;
        int pick;
        start = items_sent;
        span  = (lim_timeout < 25) ? int'(lim_timeout) + 3 : 25;
        while (items_sent - start < count)
        begin
            if ($urandom_range(0, 15) == 0) tx_idle = ~tx_idle;
            if ($urandom_range(0, 15) == 0) rx_idle = ~rx_idle;
            if (hold_at >= 0 && items_sent - start >= hold_at)
            begin
                hold_cycles = HOLD_LONG;
                hold_at     = -1;
            end
            if (pause_at >= 0 && items_sent - start >= pause_at)
            begin
                drain();
                pause_at = -1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_frame(pick_distance(), 1'b0);
            else if (pick < 65)
                send_frame(16'($urandom()), 1'b1);
            else if (pick < 85)
            begin
                len = $urandom_range(1, span);
                repeat (len) send_item(KIND_TICK, 8'($urandom()), 1'b0, '0);
            end
            else if (pick < 92)
            begin
                len = $urandom_range(1, 3);
                repeat (len) send_item(KIND_BYTE, 8'($urandom()), 1'b0, '0);
            end
            else
            begin
                // Truncated frame: whatever follows is taken as its data.
                send_item(KIND_BYTE, HEADER_BYTE, 1'b0, '0);
                len = $urandom_range(1, 2);
                repeat (len) send_item(KIND_BYTE, 8'($urandom()), 1'b0, '0);
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = rx_idle ? $urandom_range(0, 16) : 0;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        reading_t w;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_readings.size() == 0)
            begin
                fail_count++;
                $display("%0t: expected no transaction, actual mm %0d ok %0d ev %0d frame %0d",
                         $time, res_ch.filtered_mm, res_ch.status_ok,
                         res_ch.frame_event, res_ch.frame_mm);
            end
            else
            begin
                w = pending_readings.pop_front();
                if (res_ch.filtered_mm !== w.filtered_mm)
                begin
                    fail_count++;
                    $display("%0t: filtered_mm expected %0d actual %0d",
                             $time, w.filtered_mm, res_ch.filtered_mm);
                end
                if (res_ch.status_ok !== w.status_ok)
                begin
                    fail_count++;
                    $display("%0t: status_ok expected %0d actual %0d",
                             $time, w.status_ok, res_ch.status_ok);
                end
                if (res_ch.frame_event !== w.frame_event)
                begin
                    fail_count++;
                    $display("%0t: frame_event expected %0d actual %0d",
                             $time, w.frame_event, res_ch.frame_event);
                end
                if (res_ch.frame_mm !== w.frame_mm)
                begin
                    fail_count++;
                    $display("%0t: frame_mm expected %0d actual %0d",
                             $time, w.frame_mm, res_ch.frame_mm);
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run exceeded %0d cycles", $time, LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [DIST_W-1:0] a;
        logic [DIST_W-1:0] b;
        fail_count  = 0;
        items_sent  = 0;
        hold_cycles = 0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        for (int i = 0; i < RING_N; i++) ring[i] = '0;
        slot        = 0;
        fill        = 0;
        ticks_idle  = '0;
        parse_st    = SEEK_HDR;
        hi_b        = '0;
        lo_b        = '0;
        held_mm     = '0;
        held_ok     = 1'b0;
        lim_min     = MIN_DIST_RST;
        lim_max     = MAX_DIST_RST;
        lim_timeout = TIMEOUT_RST;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_MIN_DIST;
        cfg_data        <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.kind    <= KIND_BYTE;
        item_ch.rx_byte <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIR_TBL[i].kind, DIR_TBL[i].data, DIR_TBL[i].typed, DIR_TBL[i].want);

        for (int ph = 0; ph < 7; ph++)
        begin
            drain();
            case (ph)
                0: set_limits(MIN_DIST_RST, MAX_DIST_RST, TIMEOUT_RST);
                1: set_limits(16'd0, 16'hFFFF, 32'd0);
                2: set_limits(16'd1000, 16'd1000, 32'd5);
                3: set_limits(16'd3000, 16'd100, 32'd20);
                4: set_limits(16'd0, 16'hFFFF, 32'hFFFF_FFFF);
                5: set_limits(16'hFFFF, 16'hFFFF, 32'd50);
                default:
                begin
                    a = 16'($urandom_range(0, 65535));
                    b = 16'($urandom_range(0, 65535));
                    set_limits((a < b) ? a : b, (a < b) ? b : a, $urandom_range(0, 40));
                end
            endcase
            run_traffic(PHASE_ITEMS, (ph == 1) ? 80 : -1, (ph == 2) ? 100 : -1);
        end

        drain();
        if (pending_readings.size() != 0) fail_count++;
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
